// ===== rtl/kmgc_pkg.sv =====
// Shared constants, codes and types of the k-means grid point clustering block.
`default_nettype none
package kmgc_pkg;

    // Sizing of the stores
    localparam int MAX_POINTS   = 1024;
    localparam int MAX_CLUSTERS = 16;
    localparam int COORD_BITS   = 10;

    localparam int PTS_W  = $clog2(MAX_POINTS);        // point address
    localparam int CNT_W  = $clog2(MAX_POINTS + 1);    // point count, member count
    localparam int CL_W   = $clog2(MAX_CLUSTERS);      // cluster index
    localparam int CID_W  = $clog2(MAX_CLUSTERS + 1);  // cluster id incl. unassigned
    localparam int SUM_W  = COORD_BITS + PTS_W;        // coordinate sum of a cluster
    localparam int DIST_W = 2 * COORD_BITS + 1;        // squared distance
    localparam int ITER_W = 10;

    // Field widths of the channels
    localparam int OPC_W  = 3;
    localparam int IDX_W  = 10;
    localparam int STAT_W = 2;
    localparam int CFGI_W = 2;
    localparam int CFGD_W = 10;

    localparam logic [CID_W-1:0] UNASSIGNED = CID_W'(MAX_CLUSTERS);

    // Opcodes
    localparam logic [OPC_W-1:0] OP_CLEAR    = 3'd0;
    localparam logic [OPC_W-1:0] OP_LOAD     = 3'd1;
    localparam logic [OPC_W-1:0] OP_RUN      = 3'd2;
    localparam logic [OPC_W-1:0] OP_RD_POINT = 3'd3;
    localparam logic [OPC_W-1:0] OP_RD_CLUST = 3'd4;

    // Status codes
    localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL    = 2'd1;
    localparam logic [STAT_W-1:0] ST_TOO_FEW = 2'd2;
    localparam logic [STAT_W-1:0] ST_RANGE   = 2'd3;

    // Configuration register indexes
    localparam logic [CFGI_W-1:0] REG_NUM_CLUSTERS = 2'd0;
    localparam logic [CFGI_W-1:0] REG_ITER_LIMIT   = 2'd1;

    typedef struct packed {
        logic [STAT_W-1:0]     status;
        logic [4:0]            cluster_id;
        logic [COORD_BITS-1:0] center_row;
        logic [COORD_BITS-1:0] center_col;
        logic [CNT_W-1:0]      member_count;
        logic [ITER_W-1:0]     iterations_used;
        logic                  converged;
    } t_result;

endpackage
`default_nettype wire

// ===== rtl/kmgc_if.sv =====
// Request, result and configuration channel interfaces.
`default_nettype none
interface kmgc_in_if;
    import kmgc_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [OPC_W-1:0]      opcode;
    logic [COORD_BITS-1:0] row;
    logic [COORD_BITS-1:0] col;
    logic                  seed_flag;
    logic [IDX_W-1:0]      index;
    modport source (output valid, opcode, row, col, seed_flag, index, input ready);
    modport sink   (input valid, opcode, row, col, seed_flag, index, output ready);
endinterface

interface kmgc_out_if;
    import kmgc_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [STAT_W-1:0]     status;
    logic [4:0]            cluster_id;
    logic [COORD_BITS-1:0] center_row;
    logic [COORD_BITS-1:0] center_col;
    logic [CNT_W-1:0]      member_count;
    logic [ITER_W-1:0]     iterations_used;
    logic                  converged;
    modport source (output valid, status, cluster_id, center_row, center_col,
                    member_count, iterations_used, converged, input ready);
    modport sink   (input valid, status, cluster_id, center_row, center_col,
                    member_count, iterations_used, converged, output ready);
endinterface

interface kmgc_cfg_if;
    import kmgc_pkg::*;
    logic              valid;
    logic              ready;
    logic [CFGI_W-1:0] index;
    logic [CFGD_W-1:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ===== rtl/kmeans_grid_point_clustering.sv =====
// Top level: point store, Lloyd k-means sequencer and request/result channels.
//
// Usage: requests arrive on i_in (valid/ready), one result per request leaves
// on o_out (valid/ready); i_cfg writes num_clusters (index 0) and
// iteration_limit (index 1) and is always ready.
// Clear, load, read-cluster and unknown opcodes answer at once: the result
// register is loaded at the accepting edge. Read-point loads it from S_RDP,
// after the registered assignment memory read.
// In each run iteration, each point costs one read of the point and
// assignment memories, one distance per center through a single pair of
// multipliers and, if its cluster changed, one assignment write;
// each non-empty cluster costs two passes of the bit-serial divider.
// A run that lacks points or seeds answers at the accepting edge.
// One request is in work at a time; the next is taken once the result
// register is empty or being emptied, so a stalled receiver holds the block.
// Reset empties the store and seed list, zeroes member counts and last-run
// data and restores num_clusters 4, iteration_limit 500; no clearing pass.
`default_nettype none
module kmeans_grid_point_clustering (
    input  wire  i_clk,
    input  wire  i_rst_n,
    kmgc_in_if.sink    i_in,
    kmgc_out_if.source o_out,
    kmgc_cfg_if.sink   i_cfg
);
    import kmgc_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_RDP, S_CLR, S_SEED_RD, S_SEED_WR, S_IT_START, S_PT_RD,
        S_PT_DIST, S_PT_WR, S_UPD_CHK, S_UPD_ROW, S_UPD_COL, S_IT_END
    } t_state;

    t_state r_state;

    // Configuration
    logic [4:0]        r_num_k;
    logic [ITER_W-1:0] r_limit;

    // Store bookkeeping and cluster state
    logic [CNT_W-1:0]      r_count;
    logic [CID_W-1:0]      r_seed_cnt;
    logic [PTS_W-1:0]      r_seed   [MAX_CLUSTERS];
    logic [COORD_BITS-1:0] r_cen_row[MAX_CLUSTERS];
    logic [COORD_BITS-1:0] r_cen_col[MAX_CLUSTERS];
    logic [SUM_W-1:0]      r_sum_row[MAX_CLUSTERS];
    logic [SUM_W-1:0]      r_sum_col[MAX_CLUSTERS];
    logic [CNT_W-1:0]      r_size   [MAX_CLUSTERS];
    logic [ITER_W-1:0]     r_last_iter;
    logic                  r_last_conv;

    // Run sequencing
    logic [CNT_W-1:0]      r_p;
    logic [CL_W-1:0]       r_c;
    logic [PTS_W-1:0]      r_seed_addr;
    logic [ITER_W-1:0]     r_iter;
    logic                  r_moved;
    logic [DIST_W-1:0]     r_best_d;
    logic [CL_W-1:0]       r_best_c;
    logic [COORD_BITS-1:0] r_qrow;
    logic                  r_rd_err;

    // Result register
    logic    r_out_valid;
    t_result r_out;
    t_result n_out;
    logic    out_load;
    logic    run_ok;
    logic    run_stop;

    // Point memories: coordinates and assignment
    logic [2*COORD_BITS-1:0] pt_mem[MAX_POINTS];
    logic [CID_W-1:0]        as_mem[MAX_POINTS];
    logic [2*COORD_BITS-1:0] pt_rdata;
    logic [CID_W-1:0]        as_rdata;

    logic                    pt_we, pt_re, as_we, as_re;
    logic [PTS_W-1:0]        pt_addr, as_addr;
    logic [2*COORD_BITS-1:0] pt_wdata;
    logic [CID_W-1:0]        as_wdata;

    logic             accept;
    logic [CID_W-1:0] k_eff;
    logic [CL_W-1:0]  k_last;
    logic             c_last;
    logic             load_ok;

    logic [CL_W-1:0]         cen_addr, size_addr, sum_addr;
    logic [COORD_BITS-1:0]   p_row, p_col;
    logic signed [COORD_BITS:0]     dr, dc;
    logic signed [2*COORD_BITS+1:0] sq_r, sq_c;
    logic [DIST_W-1:0]       sq_dist;
    logic                    take;
    logic [CL_W-1:0]         cand_c;

    logic             div_start;
    logic [SUM_W-1:0] div_dividend;
    logic             div_done;
    logic [SUM_W-1:0] div_quo;

    // Effective K, clamped to 1..MAX_CLUSTERS
    always_comb begin
        if (r_num_k == 5'd0)
            k_eff = CID_W'(1);
        else if (CID_W'(r_num_k) > CID_W'(MAX_CLUSTERS))
            k_eff = CID_W'(MAX_CLUSTERS);
        else
            k_eff = CID_W'(r_num_k);
        k_last = CL_W'(k_eff - CID_W'(1));
        c_last = (r_c == k_last);
    end

    assign accept  = i_in.valid && i_in.ready;
    assign load_ok = (r_count < CNT_W'(MAX_POINTS));
    assign i_in.ready  = (r_state == S_IDLE) && (!r_out_valid || o_out.ready);
    assign i_cfg.ready = 1'b1;

    // Memory port control
    always_comb begin
        pt_we    = 1'b0;
        pt_re    = 1'b0;
        pt_addr  = r_p[PTS_W-1:0];
        pt_wdata = {i_in.row, i_in.col};
        as_we    = 1'b0;
        as_re    = 1'b0;
        as_addr  = r_p[PTS_W-1:0];
        as_wdata = UNASSIGNED;
        unique case (r_state)
            S_IDLE: begin
                if (accept && i_in.opcode == OP_LOAD && load_ok) begin
                    pt_we   = 1'b1;
                    pt_addr = r_count[PTS_W-1:0];
                    as_we   = 1'b1;
                    as_addr = r_count[PTS_W-1:0];
                end else if (accept && i_in.opcode == OP_RD_POINT) begin
                    as_re   = 1'b1;
                    as_addr = i_in.index[PTS_W-1:0];
                end
            end
            S_CLR:     as_we = 1'b1;
            S_SEED_RD: begin
                pt_re   = 1'b1;
                pt_addr = r_seed[r_c];
            end
            S_SEED_WR: begin
                as_we    = 1'b1;
                as_addr  = r_seed_addr;
                as_wdata = CID_W'(r_c);
            end
            S_PT_RD: begin
                pt_re = 1'b1;
                as_re = 1'b1;
            end
            S_PT_WR: begin
                as_we    = (CID_W'(r_best_c) != as_rdata);
                as_wdata = CID_W'(r_best_c);
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (pt_we) pt_mem[pt_addr] <= pt_wdata;
        if (pt_re) pt_rdata <= pt_mem[pt_addr];
    end

    always_ff @(posedge i_clk) begin
        if (as_we) as_mem[as_addr] <= as_wdata;
        if (as_re) as_rdata <= as_mem[as_addr];
    end

    // Cluster array read addresses
    always_comb begin
        cen_addr  = (r_state == S_IDLE) ? i_in.index[CL_W-1:0] : r_c;
        size_addr = (r_state == S_IDLE) ? i_in.index[CL_W-1:0]
                  : (r_state == S_PT_WR) ? r_best_c : r_c;
        sum_addr  = (r_state == S_PT_WR) ? r_best_c : r_c;
    end

    // Squared distance of the current point to center r_c
    always_comb begin
        p_row   = pt_rdata[2*COORD_BITS-1:COORD_BITS];
        p_col   = pt_rdata[COORD_BITS-1:0];
        dr      = $signed({1'b0, r_cen_row[cen_addr]}) - $signed({1'b0, p_row});
        dc      = $signed({1'b0, r_cen_col[cen_addr]}) - $signed({1'b0, p_col});
        sq_r    = dr * dr;
        sq_c    = dc * dc;
        sq_dist = {1'b0, sq_r[2*COORD_BITS-1:0]} + {1'b0, sq_c[2*COORD_BITS-1:0]};
        take    = (r_c == '0) || (sq_dist < r_best_d);
        cand_c  = take ? r_c : r_best_c;
    end

    // Divider operands
    always_comb begin
        div_start    = 1'b0;
        div_dividend = r_sum_row[sum_addr];
        if (r_state == S_UPD_CHK && r_size[size_addr] != '0) begin
            div_start = 1'b1;
        end else if (r_state == S_UPD_ROW && div_done) begin
            div_start    = 1'b1;
            div_dividend = r_sum_col[sum_addr];
        end
    end

    kmgc_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (r_size[size_addr]),
        .o_done     (div_done),
        .o_quotient (div_quo)
    );

    // Next result and when it is loaded
    always_comb begin
        run_ok   = (r_count >= CNT_W'(k_eff)) && (r_seed_cnt >= k_eff);
        run_stop = !r_moved || (r_iter >= r_limit);
        n_out    = '0;
        out_load = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                out_load = accept && (i_in.opcode != OP_RD_POINT) &&
                           !(i_in.opcode == OP_RUN && run_ok);
                unique case (i_in.opcode)
                    OP_LOAD: begin
                        if (!load_ok) n_out.status = ST_FULL;
                    end
                    OP_RUN: begin
                        if (!run_ok) n_out.status = ST_TOO_FEW;
                    end
                    OP_RD_CLUST: begin
                        if (i_in.index >= IDX_W'(MAX_CLUSTERS)) begin
                            n_out.status = ST_RANGE;
                        end else begin
                            n_out.cluster_id      = 5'(i_in.index);
                            n_out.center_row      = r_cen_row[cen_addr];
                            n_out.center_col      = r_cen_col[cen_addr];
                            n_out.member_count    = r_size[size_addr];
                            n_out.iterations_used = r_last_iter;
                            n_out.converged       = r_last_conv;
                        end
                    end
                    default: ;
                endcase
            end
            S_RDP: begin
                out_load = 1'b1;
                if (r_rd_err) n_out.status     = ST_RANGE;
                else          n_out.cluster_id = 5'(as_rdata);
            end
            S_IT_END: begin
                out_load              = run_stop;
                n_out.iterations_used = r_iter;
                n_out.converged       = !r_moved;
            end
            default: ;
        endcase
    end

    // Sequencer, cluster state and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_num_k     <= 5'd4;
            r_limit     <= ITER_W'(500);
            r_count     <= '0;
            r_seed_cnt  <= '0;
            r_last_iter <= '0;
            r_last_conv <= 1'b0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < MAX_CLUSTERS; i++) r_size[i] <= '0;
        end else begin
            if (i_cfg.valid && i_cfg.ready) begin
                unique case (i_cfg.index)
                    REG_NUM_CLUSTERS: r_num_k <= i_cfg.data[4:0];
                    REG_ITER_LIMIT:   r_limit <= i_cfg.data[ITER_W-1:0];
                    default: ;
                endcase
            end

            if (out_load) begin
                r_out       <= n_out;
                r_out_valid <= 1'b1;
            end else if (o_out.valid && o_out.ready) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        unique case (i_in.opcode)
                            OP_CLEAR: begin
                                r_count     <= '0;
                                r_seed_cnt  <= '0;
                                r_last_iter <= '0;
                                r_last_conv <= 1'b0;
                                for (int i = 0; i < MAX_CLUSTERS; i++) r_size[i] <= '0;
                            end
                            OP_LOAD: begin
                                if (load_ok) begin
                                    if (i_in.seed_flag &&
                                        r_seed_cnt < CID_W'(MAX_CLUSTERS)) begin
                                        r_seed[r_seed_cnt[CL_W-1:0]] <= r_count[PTS_W-1:0];
                                        r_seed_cnt <= r_seed_cnt + CID_W'(1);
                                    end
                                    r_count <= r_count + CNT_W'(1);
                                end
                            end
                            OP_RUN: begin
                                if (run_ok) begin
                                    r_p     <= '0;
                                    r_state <= S_CLR;
                                end
                            end
                            OP_RD_POINT: begin
                                r_rd_err <= (CNT_W'(i_in.index) >= r_count);
                                r_state  <= S_RDP;
                            end
                            default: ;
                        endcase
                    end
                end
                S_RDP: r_state <= S_IDLE;
                // Run start: all points unassigned, then seeds take their clusters
                S_CLR: begin
                    r_p <= r_p + CNT_W'(1);
                    if (r_p + CNT_W'(1) == r_count) begin
                        r_c     <= '0;
                        r_state <= S_SEED_RD;
                    end
                end
                S_SEED_RD: begin
                    r_seed_addr <= r_seed[r_c];
                    r_state     <= S_SEED_WR;
                end
                S_SEED_WR: begin
                    r_cen_row[r_c] <= pt_rdata[2*COORD_BITS-1:COORD_BITS];
                    r_cen_col[r_c] <= pt_rdata[COORD_BITS-1:0];
                    if (c_last) begin
                        r_iter  <= ITER_W'(1);
                        r_state <= S_IT_START;
                    end else begin
                        r_c     <= r_c + CL_W'(1);
                        r_state <= S_SEED_RD;
                    end
                end
                // Iteration: assign every point and accumulate its cluster sums
                S_IT_START: begin
                    for (int i = 0; i < MAX_CLUSTERS; i++) begin
                        r_sum_row[i] <= '0;
                        r_sum_col[i] <= '0;
                        r_size[i]    <= '0;
                    end
                    r_p     <= '0;
                    r_moved <= 1'b0;
                    r_state <= S_PT_RD;
                end
                S_PT_RD: begin
                    r_c     <= '0;
                    r_state <= S_PT_DIST;
                end
                S_PT_DIST: begin
                    if (take) r_best_d <= sq_dist;
                    r_best_c <= cand_c;
                    r_c      <= r_c + CL_W'(1);
                    if (c_last) r_state <= S_PT_WR;
                end
                S_PT_WR: begin
                    if (CID_W'(r_best_c) != as_rdata) r_moved <= 1'b1;
                    r_sum_row[sum_addr] <= r_sum_row[sum_addr] + SUM_W'(p_row);
                    r_sum_col[sum_addr] <= r_sum_col[sum_addr] + SUM_W'(p_col);
                    r_size[size_addr]   <= r_size[size_addr] + CNT_W'(1);
                    r_p <= r_p + CNT_W'(1);
                    if (r_p + CNT_W'(1) == r_count) begin
                        r_c     <= '0;
                        r_state <= S_UPD_CHK;
                    end else begin
                        r_state <= S_PT_RD;
                    end
                end
                // Update: non-empty clusters move to their truncated mean
                S_UPD_CHK: begin
                    if (r_size[size_addr] != '0) begin
                        r_state <= S_UPD_ROW;
                    end else if (c_last) begin
                        r_state <= S_IT_END;
                    end else begin
                        r_c <= r_c + CL_W'(1);
                    end
                end
                S_UPD_ROW: begin
                    if (div_done) begin
                        r_qrow  <= div_quo[COORD_BITS-1:0];
                        r_state <= S_UPD_COL;
                    end
                end
                S_UPD_COL: begin
                    if (div_done) begin
                        r_cen_row[r_c] <= r_qrow;
                        r_cen_col[r_c] <= div_quo[COORD_BITS-1:0];
                        if (c_last) begin
                            r_state <= S_IT_END;
                        end else begin
                            r_c     <= r_c + CL_W'(1);
                            r_state <= S_UPD_CHK;
                        end
                    end
                end
                S_IT_END: begin
                    if (run_stop) begin
                        r_last_iter <= r_iter;
                        r_last_conv <= !r_moved;
                        r_state     <= S_IDLE;
                    end else begin
                        r_iter  <= r_iter + ITER_W'(1);
                        r_state <= S_IT_START;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out.valid           = r_out_valid;
    assign o_out.status          = r_out.status;
    assign o_out.cluster_id      = r_out.cluster_id;
    assign o_out.center_row      = r_out.center_row;
    assign o_out.center_col      = r_out.center_col;
    assign o_out.member_count    = r_out.member_count;
    assign o_out.iterations_used = r_out.iterations_used;
    assign o_out.converged       = r_out.converged;

endmodule
`default_nettype wire

// ===== rtl/kmgc_div.sv =====
// Iterative restoring divider: coordinate sum by member count, one bit a cycle.
`default_nettype none
module kmgc_div (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  wire                         i_start,
    input  wire [kmgc_pkg::SUM_W-1:0]   i_dividend,
    input  wire [kmgc_pkg::CNT_W-1:0]   i_divisor,
    output logic                        o_done,
    output logic [kmgc_pkg::SUM_W-1:0]  o_quotient
);
    import kmgc_pkg::*;

    localparam int STEP_W = $clog2(SUM_W + 1);

    logic              r_busy;
    logic              r_done;
    logic [STEP_W-1:0] r_cnt;
    logic [CNT_W-1:0]  r_rem;
    logic [SUM_W-1:0]  r_quo;
    logic [CNT_W-1:0]  r_div;

    logic [CNT_W:0] rem_sh;
    logic [CNT_W:0] rem_sub;
    logic           fits;

    // One shift-compare-subtract step
    always_comb begin
        rem_sh  = {r_rem, r_quo[SUM_W-1]};
        rem_sub = rem_sh - {1'b0, r_div};
        fits    = (rem_sh >= {1'b0, r_div});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= STEP_W'(SUM_W);
                r_rem  <= '0;
                r_quo  <= i_dividend;
                r_div  <= i_divisor;
            end else if (r_busy) begin
                r_rem <= fits ? rem_sub[CNT_W-1:0] : rem_sh[CNT_W-1:0];
                r_quo <= {r_quo[SUM_W-2:0], fits};
                r_cnt <= r_cnt - STEP_W'(1);
                if (r_cnt == STEP_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule
`default_nettype wire
